>>> src/ps2mt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ps2mt_pkg;

    // Coordinate range of the cursor
    localparam int COORD_BITS  = 12;
    localparam int COORD_MAX_I = (1 << COORD_BITS) - 1;
    localparam int SUM_BITS    = COORD_BITS + 2;

    // Field widths
    localparam int BYTE_BITS  = 8;
    localparam int SIZE_BITS  = 13;
    localparam int WHEEL_BITS = 16;
    localparam int COUNT_BITS = 32;
    localparam int IDX_BITS   = 2;

    typedef logic [COORD_BITS-1:0]        t_coord;
    typedef logic [BYTE_BITS-1:0]         t_byte;
    typedef logic [SIZE_BITS-1:0]         t_size;
    typedef logic signed [WHEEL_BITS-1:0] t_wheel;
    typedef logic [COUNT_BITS-1:0]        t_count;

    localparam t_coord COORD_MAX = t_coord'(COORD_MAX_I);
    localparam t_coord RESET_X   = t_coord'((640 > COORD_MAX_I) ? COORD_MAX_I : 640);
    localparam t_coord RESET_Y   = t_coord'((360 > COORD_MAX_I) ? COORD_MAX_I : 360);
    localparam t_size  RESET_WIDTH  = t_size'(1280);
    localparam t_size  RESET_HEIGHT = t_size'(720);

    localparam t_wheel WHEEL_MAX = t_wheel'(32767);
    localparam t_wheel WHEEL_MIN = t_wheel'(-32768);

    // Bit positions in the first packet byte
    localparam int SYNC_POS  = 3;
    localparam int LEFT_POS  = 0;
    localparam int RIGHT_POS = 1;

    // Input opcodes
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_READ = 1'b1
    } t_opcode;

    // Configuration register indexes
    typedef enum logic [IDX_BITS-1:0] {
        CFG_WHEEL_MODE    = 2'd0,
        CFG_SCREEN_WIDTH  = 2'd1,
        CFG_SCREEN_HEIGHT = 2'd2
    } t_cfg_idx;

    // Decoded configuration
    typedef struct packed {
        logic   wheel_mode;
        t_coord x_lim;
        t_coord y_lim;
    } t_cfg;

    // Assembler to tracker
    typedef struct packed {
        logic  read_cmd;
        logic  done;
        t_byte flags;
        t_byte dx;
        t_byte dy;
        t_byte wd;
    } t_pkt;

    // Result item
    typedef struct packed {
        t_coord cursor_x;
        t_coord cursor_y;
        logic   left_button;
        logic   right_button;
        t_wheel wheel_total;
        t_count packets_seen;
        logic   packet_accepted;
    } t_res;

    // Screen size to largest coordinate; zero acts as one
    function automatic t_coord limit_of(input t_size size);
        t_size m;
        m = size - t_size'(1);
        if (size == '0) begin
            return '0;
        end
        if (int'(m) > COORD_MAX_I) begin
            return COORD_MAX;
        end
        return t_coord'(m);
    endfunction

endpackage

`default_nettype wire

>>> src/ps2mt_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ps2mt_in_if;
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    ps2mt_pkg::t_byte     rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> src/ps2mt_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ps2mt_out_if;
    logic                 valid;
    logic                 ready;
    ps2mt_pkg::t_coord    cursor_x;
    ps2mt_pkg::t_coord    cursor_y;
    logic                 left_button;
    logic                 right_button;
    ps2mt_pkg::t_wheel    wheel_total;
    ps2mt_pkg::t_count    packets_seen;
    logic                 packet_accepted;

    modport source (
        output valid, output cursor_x, output cursor_y, output left_button,
        output right_button, output wheel_total, output packets_seen,
        output packet_accepted, input ready
    );
    modport sink (
        input valid, input cursor_x, input cursor_y, input left_button,
        input right_button, input wheel_total, input packets_seen,
        input packet_accepted, output ready
    );
endinterface

`default_nettype wire

>>> src/ps2_mouse_packet_tracker.sv
// Mouse packet tracker.
// Input channel i_in carries one item per transfer: opcode 0 passes a byte
// received from the mouse, opcode 1 reads and clears the wheel total.
// Bytes are gathered into 3-byte packets, or 4-byte packets in wheel mode;
// a finished packet with the sync bit set updates buttons, cursor, wheel sum
// and packet count. Output channel o_out returns one result per input item.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data):
// index 0 wheel mode, 1 screen width, 2 screen height; write only when idle.
// Each input item passes the input register, then the result register, which
// drives o_out.
// Throughput: one item per cycle while o_out is not stalled, since all
// per-item work is a single pass from the input register to the result
// register and the tracked state updates in that same cycle.
// Reset (synchronous, active low) clears the byte position, buttons, wheel
// sum and count, sets the cursor to 640/360 and the screen to 1280x720.
// When the receiver stalls, the result register holds and one more item is
// taken into the input register; after that i_in.ready drops until o_out
// drains.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_tracker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    ps2mt_in_if.sink                               i_in,
    ps2mt_out_if.source                            o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [ps2mt_pkg::IDX_BITS-1:0]    i_cfg_idx,
    input  wire ps2mt_pkg::t_size                  i_cfg_data
);

    logic              r_in_vld;
    logic              r_in_op;
    ps2mt_pkg::t_byte  r_in_byte;
    logic              r_out_vld;
    ps2mt_pkg::t_res   r_out;

    logic              w_adv;
    logic              w_step;
    ps2mt_pkg::t_cfg   w_cfg;
    ps2mt_pkg::t_pkt   w_pkt;
    ps2mt_pkg::t_res   w_res;

    // Handshake: result stage frees when empty or taken
    assign w_adv      = !r_out_vld || o_out.ready;
    assign w_step     = r_in_vld && w_adv;
    assign i_in.ready = !r_in_vld || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_op   <= i_in.opcode;
            r_in_byte <= i_in.rx_byte;
        end
    end

    ps2mt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    ps2mt_assembler u_asm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_opcode     (r_in_op),
        .i_rx_byte    (r_in_byte),
        .i_wheel_mode (w_cfg.wheel_mode),
        .o_pkt        (w_pkt)
    );

    ps2mt_tracker u_trk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_pkt   (w_pkt),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.cursor_x        = r_out.cursor_x;
    assign o_out.cursor_y        = r_out.cursor_y;
    assign o_out.left_button     = r_out.left_button;
    assign o_out.right_button    = r_out.right_button;
    assign o_out.wheel_total     = r_out.wheel_total;
    assign o_out.packets_seen    = r_out.packets_seen;
    assign o_out.packet_accepted = r_out.packet_accepted;

endmodule

`default_nettype wire

>>> src/ps2mt_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2mt_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ps2mt_pkg::IDX_BITS-1:0]    i_cfg_idx,
    input  wire ps2mt_pkg::t_size                  i_cfg_data,
    output ps2mt_pkg::t_cfg                        o_cfg
);

    logic              r_wheel_mode;
    ps2mt_pkg::t_coord r_x_lim;
    ps2mt_pkg::t_coord r_y_lim;

    // Sizes are stored as limits, ready for clamping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_mode <= 1'b0;
            r_x_lim      <= ps2mt_pkg::limit_of(ps2mt_pkg::RESET_WIDTH);
            r_y_lim      <= ps2mt_pkg::limit_of(ps2mt_pkg::RESET_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ps2mt_pkg::CFG_WHEEL_MODE:    r_wheel_mode <= i_cfg_data[0];
                ps2mt_pkg::CFG_SCREEN_WIDTH:  r_x_lim <= ps2mt_pkg::limit_of(i_cfg_data);
                ps2mt_pkg::CFG_SCREEN_HEIGHT: r_y_lim <= ps2mt_pkg::limit_of(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.wheel_mode = r_wheel_mode;
    assign o_cfg.x_lim      = r_x_lim;
    assign o_cfg.y_lim      = r_y_lim;

endmodule

`default_nettype wire

>>> src/ps2mt_assembler.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2mt_assembler (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic              i_opcode,
    input  wire ps2mt_pkg::t_byte  i_rx_byte,
    input  wire logic              i_wheel_mode,
    output ps2mt_pkg::t_pkt        o_pkt
);

    logic [ps2mt_pkg::IDX_BITS-1:0] r_idx;
    logic [ps2mt_pkg::IDX_BITS-1:0] n_idx;
    ps2mt_pkg::t_byte               r_held [3];
    logic [ps2mt_pkg::IDX_BITS-1:0] w_last;
    logic                           w_is_byte;
    logic                           w_gather;
    logic                           w_done;

    // Current mode decides where a packet ends
    assign w_last    = i_wheel_mode ? 2'd3 : 2'd2;
    assign w_is_byte = (i_opcode == ps2mt_pkg::OP_BYTE);
    assign w_gather  = w_is_byte && (r_idx < w_last);
    assign w_done    = w_is_byte && !(r_idx < w_last);

    // Byte position within the packet
    always_comb begin
        n_idx = r_idx;
        if (w_gather) begin
            n_idx = r_idx + 2'd1;
        end else if (w_done) begin
            n_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_step) begin
            r_idx <= n_idx;
        end
    end

    // Held bytes; the index never reaches 3 while gathering
    always_ff @(posedge i_clk) begin
        if (i_step && w_gather) begin
            r_held[r_idx] <= i_rx_byte;
        end
    end

    // Packet fields; the closing byte is taken live
    always_comb begin
        o_pkt.read_cmd = (i_opcode == ps2mt_pkg::OP_READ);
        o_pkt.done     = w_done;
        o_pkt.flags    = r_held[0];
        o_pkt.dx       = r_held[1];
        o_pkt.dy       = (r_idx == 2'd2) ? i_rx_byte : r_held[2];
        o_pkt.wd       = (i_wheel_mode && (r_idx == 2'd3)) ? i_rx_byte : '0;
    end

endmodule

`default_nettype wire

>>> src/ps2mt_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

module ps2mt_tracker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire ps2mt_pkg::t_pkt   i_pkt,
    input  wire ps2mt_pkg::t_cfg   i_cfg,
    output ps2mt_pkg::t_res        o_res
);

    ps2mt_pkg::t_coord r_pos_x;
    ps2mt_pkg::t_coord r_pos_y;
    logic              r_left;
    logic              r_right;
    ps2mt_pkg::t_wheel r_wheel;
    ps2mt_pkg::t_count r_count;

    ps2mt_pkg::t_coord n_pos_x;
    ps2mt_pkg::t_coord n_pos_y;
    logic              n_left;
    logic              n_right;
    ps2mt_pkg::t_wheel n_wheel;
    ps2mt_pkg::t_count n_count;

    logic                                   w_accept;
    logic signed [ps2mt_pkg::SUM_BITS-1:0]  w_sum_x;
    logic signed [ps2mt_pkg::SUM_BITS-1:0]  w_sum_y;
    logic signed [ps2mt_pkg::SUM_BITS-1:0]  w_lim_x;
    logic signed [ps2mt_pkg::SUM_BITS-1:0]  w_lim_y;
    ps2mt_pkg::t_coord                      w_clamp_x;
    ps2mt_pkg::t_coord                      w_clamp_y;
    logic signed [ps2mt_pkg::WHEEL_BITS:0]  w_wsum;
    ps2mt_pkg::t_wheel                      w_wsat;

    assign w_accept = i_pkt.done && i_pkt.flags[ps2mt_pkg::SYNC_POS];

    // Cursor move: x adds, y subtracts
    assign w_sum_x = $signed({2'b00, r_pos_x})
                   + ps2mt_pkg::SUM_BITS'($signed(i_pkt.dx));
    assign w_sum_y = $signed({2'b00, r_pos_y})
                   - ps2mt_pkg::SUM_BITS'($signed(i_pkt.dy));
    assign w_lim_x = $signed({2'b00, i_cfg.x_lim});
    assign w_lim_y = $signed({2'b00, i_cfg.y_lim});

    // Clamp to the screen
    always_comb begin
        if (w_sum_x < 0) begin
            w_clamp_x = '0;
        end else if (w_sum_x > w_lim_x) begin
            w_clamp_x = i_cfg.x_lim;
        end else begin
            w_clamp_x = w_sum_x[ps2mt_pkg::COORD_BITS-1:0];
        end
        if (w_sum_y < 0) begin
            w_clamp_y = '0;
        end else if (w_sum_y > w_lim_y) begin
            w_clamp_y = i_cfg.y_lim;
        end else begin
            w_clamp_y = w_sum_y[ps2mt_pkg::COORD_BITS-1:0];
        end
    end

    // Saturating wheel sum
    assign w_wsum = (ps2mt_pkg::WHEEL_BITS + 1)'(r_wheel)
                  + (ps2mt_pkg::WHEEL_BITS + 1)'($signed(i_pkt.wd));

    always_comb begin
        if (w_wsum[ps2mt_pkg::WHEEL_BITS] == w_wsum[ps2mt_pkg::WHEEL_BITS-1]) begin
            w_wsat = w_wsum[ps2mt_pkg::WHEEL_BITS-1:0];
        end else if (w_wsum[ps2mt_pkg::WHEEL_BITS]) begin
            w_wsat = ps2mt_pkg::WHEEL_MIN;
        end else begin
            w_wsat = ps2mt_pkg::WHEEL_MAX;
        end
    end

    // Next state
    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_left  = r_left;
        n_right = r_right;
        n_wheel = r_wheel;
        n_count = r_count;
        if (i_pkt.read_cmd) begin
            n_wheel = '0;
        end else if (w_accept) begin
            n_pos_x = w_clamp_x;
            n_pos_y = w_clamp_y;
            n_left  = i_pkt.flags[ps2mt_pkg::LEFT_POS];
            n_right = i_pkt.flags[ps2mt_pkg::RIGHT_POS];
            n_wheel = w_wsat;
            n_count = r_count + ps2mt_pkg::t_count'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= ps2mt_pkg::RESET_X;
            r_pos_y <= ps2mt_pkg::RESET_Y;
            r_left  <= 1'b0;
            r_right <= 1'b0;
            r_wheel <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_left  <= n_left;
            r_right <= n_right;
            r_wheel <= n_wheel;
            r_count <= n_count;
        end
    end

    // Result for this item
    always_comb begin
        o_res.cursor_x        = n_pos_x;
        o_res.cursor_y        = n_pos_y;
        o_res.left_button     = n_left;
        o_res.right_button    = n_right;
        o_res.wheel_total     = i_pkt.read_cmd ? r_wheel : '0;
        o_res.packets_seen    = n_count;
        o_res.packet_accepted = w_accept;
    end

endmodule

`default_nettype wire

>>> bench/ps2mt_checker.sv
`timescale 1ns / 1ps

module ps2mt_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    ps2mt_in_if                                 i_in_ch,
    ps2mt_out_if                                i_out_ch,
    input  wire logic                           i_cfg_we,
    input  wire logic [ps2mt_pkg::IDX_BITS-1:0] i_cfg_idx,
    input  wire ps2mt_pkg::t_size               i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_packets
);
    import ps2mt_pkg::*;

    // Shadow copies of the configuration registers
    logic   wheel_on;
    t_size  width_reg;
    t_size  height_reg;

    // Shadow tracker state
    logic [1:0] gather_pos;
    t_byte      gathered [3];
    t_coord     cur_col;
    t_coord     cur_row;
    logic       left_held;
    logic       right_held;
    t_wheel     wheel_acc;
    t_count     good_packets;

    // Expected results, oldest first
    t_res       awaited_results [$];

    // Largest coordinate for a screen size; zero acts as one
    function automatic int coord_limit(input t_size size);
        int lim;
        lim = (size == '0) ? 0 : int'(size) - 1;
        return (lim > COORD_MAX_I) ? COORD_MAX_I : lim;
    endfunction

    function automatic int clamp_coord(input int v, input int hi);
        if (v < 0) begin
            return 0;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic int sext_byte(input t_byte b);
        return int'($signed(b));
    endfunction

    // Work out the result of one input transfer and advance the shadow state
    task automatic decode_item(input t_opcode op, input t_byte rx, output t_res res);
        t_byte      flags;
        int         dx;
        int         dy;
        int         wd;
        int         wsum;
        logic [1:0] last_pos;
        res = '0;
        if (op == OP_READ) begin
            res.wheel_total = wheel_acc;
            wheel_acc = '0;
        end else begin
            last_pos = wheel_on ? 2'd3 : 2'd2;
            if (gather_pos < last_pos) begin
                gathered[gather_pos] = rx;
                gather_pos = gather_pos + 2'd1;
            end else begin
                // Packet complete; a leftover fourth slot after a mode switch
                // means the current byte is ignored
                flags = gathered[0];
                dx = sext_byte(gathered[1]);
                dy = (gather_pos == 2'd2) ? sext_byte(rx) : sext_byte(gathered[2]);
                wd = (wheel_on && gather_pos == 2'd3) ? sext_byte(rx) : 0;
                gather_pos = 2'd0;
                if (flags[SYNC_POS]) begin
                    left_held = flags[LEFT_POS];
                    right_held = flags[RIGHT_POS];
                    cur_col = t_coord'(clamp_coord(int'(cur_col) + dx,
                                                   coord_limit(width_reg)));
                    cur_row = t_coord'(clamp_coord(int'(cur_row) - dy,
                                                   coord_limit(height_reg)));
                    wsum = int'(wheel_acc) + wd;
                    if (wsum > int'(WHEEL_MAX)) begin
                        wsum = int'(WHEEL_MAX);
                    end
                    if (wsum < int'(WHEEL_MIN)) begin
                        wsum = int'(WHEEL_MIN);
                    end
                    wheel_acc = t_wheel'(wsum);
                    good_packets = good_packets + t_count'(1);
                    res.packet_accepted = 1'b1;
                end
            end
        end
        res.cursor_x = cur_col;
        res.cursor_y = cur_row;
        res.left_button = left_held;
        res.right_button = right_held;
        res.packets_seen = good_packets;
    endtask

    task automatic report_mismatch(input string field, input logic signed [32:0] want,
                                   input logic signed [32:0] got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        o_fail_count++;
    endtask

    task automatic compare_result(input t_res want, input t_res got);
        if (got.cursor_x !== want.cursor_x) begin
            report_mismatch("cursor_x", want.cursor_x, got.cursor_x);
        end
        if (got.cursor_y !== want.cursor_y) begin
            report_mismatch("cursor_y", want.cursor_y, got.cursor_y);
        end
        if (got.left_button !== want.left_button) begin
            report_mismatch("left_button", want.left_button, got.left_button);
        end
        if (got.right_button !== want.right_button) begin
            report_mismatch("right_button", want.right_button, got.right_button);
        end
        if (got.wheel_total !== want.wheel_total) begin
            report_mismatch("wheel_total", want.wheel_total, got.wheel_total);
        end
        if (got.packets_seen !== want.packets_seen) begin
            report_mismatch("packets_seen", want.packets_seen, got.packets_seen);
        end
        if (got.packet_accepted !== want.packet_accepted) begin
            report_mismatch("packet_accepted", want.packet_accepted, got.packet_accepted);
        end
    endtask

    // Follow register writes and both channels
    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            wheel_on = 1'b0;
            width_reg = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            gather_pos = 2'd0;
            gathered[0] = '0;
            gathered[1] = '0;
            gathered[2] = '0;
            cur_col = RESET_X;
            cur_row = RESET_Y;
            left_held = 1'b0;
            right_held = 1'b0;
            wheel_acc = '0;
            good_packets = '0;
            awaited_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WHEEL_MODE:    wheel_on = i_cfg_data[0];
                    CFG_SCREEN_WIDTH:  width_reg = i_cfg_data;
                    CFG_SCREEN_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            // Result transfer: compare against the oldest expectation
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.cursor_x = i_out_ch.cursor_x;
                got.cursor_y = i_out_ch.cursor_y;
                got.left_button = i_out_ch.left_button;
                got.right_button = i_out_ch.right_button;
                got.wheel_total = i_out_ch.wheel_total;
                got.packets_seen = i_out_ch.packets_seen;
                got.packet_accepted = i_out_ch.packet_accepted;
                if (awaited_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected", $time);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_result(want, got);
                end
            end
            // Input transfer: predict its result
            if (i_in_ch.valid && i_in_ch.ready) begin
                decode_item(t_opcode'(i_in_ch.opcode), i_in_ch.rx_byte, want);
                awaited_results.push_back(want);
            end
        end
        o_pending = awaited_results.size();
        o_packets = int'(good_packets);
    end

endmodule

>>> bench/tb_ps2_mouse_packet_tracker.sv
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_tracker;
    import ps2mt_pkg::*;

    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SAT_PACKETS    = 270;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                cfg_we;
    logic [IDX_BITS-1:0] cfg_idx;
    t_size               cfg_data;

    int mismatches;
    int pending;
    int packets;

    // Stimulus bookkeeping
    bit   hold_req = 1'b0;
    bit   no_gaps = 1'b0;
    logic wheel_mode_now = 1'b0;
    int   frame_pos = 0;
    int   burst_left = 0;
    int   n_items = 0;
    int   n_reads = 0;
    int   n_writes = 0;
    int   idle_cycles = 0;

    ps2mt_in_if  in_ch ();
    ps2mt_out_if out_ch ();

    ps2_mouse_packet_tracker i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ps2mt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (mismatches),
        .o_pending    (pending),
        .o_packets    (packets)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("ps2_mouse_packet_tracker verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: stall patterns that change over time, plus one long hold-off
    initial begin
        int stall_mode;
        int mode_left;
        int beat;
        stall_mode = 0;
        mode_left = 0;
        beat = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 128);
                end
                mode_left--;
                beat++;
                case (stall_mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 9) < 7);
                    2: out_ch.ready <= (beat % 3 == 0);
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one item, in bursts with random gaps; returns at its transfer edge
    task automatic send_item(input t_opcode op, input t_byte b);
        int   gap;
        logic took;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (no_gaps) begin
                gap = 0;
            end
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.rx_byte <= b;
        do begin
            @(negedge i_clk);
            took = in_ch.ready;
            @(posedge i_clk);
        end while (!took);
        n_items++;
        if (op == OP_READ) begin
            n_reads++;
        end else if (frame_pos < (wheel_mode_now ? 3 : 2)) begin
            frame_pos++;
        end else begin
            frame_pos = 0;
        end
    endtask

    task automatic send_packet(input t_byte flags, input t_byte dx, input t_byte dy,
                               input t_byte wd);
        send_item(OP_BYTE, flags);
        send_item(OP_BYTE, dx);
        send_item(OP_BYTE, dy);
        if (wheel_mode_now) begin
            send_item(OP_BYTE, wd);
        end
    endtask

    // Stop offering, wait for every result, then let the pipeline go quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input t_size val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        n_writes++;
        if (idx == CFG_WHEEL_MODE) begin
            wheel_mode_now = val[0];
        end
    endtask

    // Fill the partial packet so the next byte starts a new one
    task automatic realign();
        while (frame_pos != 0) send_item(OP_BYTE, 8'h00);
    endtask

    function automatic t_byte pick_flags(input bit allow_drop);
        t_byte f;
        f = t_byte'($urandom);
        f[SYNC_POS] = !allow_drop || ($urandom_range(0, 7) != 0);
        return f;
    endfunction

    function automatic t_byte pick_delta();
        case ($urandom_range(0, 7))
            0: return 8'h7F;
            1: return 8'h80;
            2: return t_byte'($urandom_range(0, 6) - 3);
            default: return t_byte'($urandom);
        endcase
    endfunction

    function automatic t_size pick_size();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return t_size'(1);
            2: return t_size'(4096);
            3: return '1;
            4: return RESET_WIDTH;
            5: return t_size'($urandom_range(2, 64));
            default: return t_size'($urandom_range(0, 8191));
        endcase
    endfunction

    // Mostly well-formed packets, with reads, junk packets and stray bytes
    task automatic mixed_traffic(input int n_pkts);
        int r;
        repeat (n_pkts) begin
            r = $urandom_range(0, 49);
            if (r < 5) begin
                send_item(OP_READ, t_byte'($urandom));
            end else if (r == 5) begin
                send_item(OP_BYTE, t_byte'($urandom));
            end else if (r < 9) begin
                send_packet(t_byte'($urandom), t_byte'($urandom), t_byte'($urandom),
                            t_byte'($urandom));
            end else begin
                send_packet(pick_flags(1'b1), pick_delta(), pick_delta(), pick_delta());
            end
        end
    endtask

    // Drive the wheel sum into one saturation limit, picked at random
    task automatic wheel_saturation();
        bit go_up;
        settle();
        set_reg(CFG_WHEEL_MODE, t_size'(1));
        set_reg(CFG_SCREEN_WIDTH, t_size'(4096));
        set_reg(CFG_SCREEN_HEIGHT, t_size'(4096));
        realign();
        go_up = ($urandom_range(0, 1) == 1);
        send_item(OP_READ, t_byte'($urandom));
        repeat (SAT_PACKETS) begin
            send_packet(pick_flags(1'b0), pick_delta(), pick_delta(),
                        go_up ? t_byte'($urandom_range(122, 127))
                              : t_byte'(256 - $urandom_range(122, 128)));
        end
        send_item(OP_READ, t_byte'($urandom));
        send_item(OP_READ, t_byte'($urandom));
    endtask

    // Main stimulus
    initial begin
        t_size w;
        t_size h;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.opcode <= OP_BYTE;
        in_ch.rx_byte <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_WHEEL_MODE;
        cfg_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: read in the middle of a packet, extreme deltas,
        // all flag bits set, then a packet without the sync bit
        send_item(OP_BYTE, 8'h09);
        send_item(OP_READ, 8'hFF);
        send_item(OP_BYTE, 8'h7F);
        send_item(OP_BYTE, 8'h80);
        send_packet(8'hFF, 8'h80, 8'h7F, 8'h00);
        send_packet(8'h00, 8'hFF, 8'hFF, 8'h00);

        // A wheel packet, then switch to three-byte mode with three bytes held
        settle();
        set_reg(CFG_WHEEL_MODE, t_size'(1));
        send_packet(8'h0A, 8'h01, 8'hFF, 8'h80);
        send_item(OP_READ, 8'h00);
        send_item(OP_BYTE, 8'h09);
        send_item(OP_BYTE, 8'h10);
        send_item(OP_BYTE, 8'h20);
        settle();
        set_reg(CFG_WHEEL_MODE, t_size'(0));
        send_item(OP_BYTE, 8'h55);

        // Zero screen size pins the cursor to the origin
        settle();
        set_reg(CFG_SCREEN_WIDTH, '0);
        set_reg(CFG_SCREEN_HEIGHT, '0);
        send_packet(8'h08, 8'h7F, 8'h80, 8'h00);

        // Random phases, each with its own settings
        for (int ph = 0; ph < 16; ph++) begin
            settle();
            case (ph)
                0: begin w = '1; h = t_size'(4096); end
                1: begin w = t_size'(1); h = t_size'(1); end
                2: begin w = t_size'(4096); h = '0; end
                default: begin w = pick_size(); h = pick_size(); end
            endcase
            set_reg(CFG_WHEEL_MODE, t_size'($urandom_range(0, 1)));
            set_reg(CFG_SCREEN_WIDTH, w);
            set_reg(CFG_SCREEN_HEIGHT, h);
            if (ph == 3) begin
                // Long result stall while items keep coming
                hold_req = 1'b1;
                no_gaps = 1'b1;
            end
            if ($urandom_range(0, 1) == 1) begin
                realign();
            end
            mixed_traffic((ph == 3) ? 6 : $urandom_range(1, 4));
            no_gaps = 1'b0;
            // Sometimes leave a packet half gathered across the next write
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) send_item(OP_BYTE, pick_flags(1'b1));
            end
            if (ph == 7) begin
                wheel_saturation();
            end
        end

        // Drain and let any stray result show up
        settle();
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);
        $display("Run covered %0d input transfers (%0d wheel reads), %0d good packets,",
                 n_items, n_reads, packets);
        $display("%0d register writes including zero, one and oversize screen limits.",
                 n_writes);
        if (mismatches == 0 && pending == 0) begin
            $display("ps2_mouse_packet_tracker verification clean");
        end else begin
            $display("ps2_mouse_packet_tracker verification failed");
        end
        $finish;
    end

endmodule
